// File: rtl/ffha_pkg.sv
// Shared types and constants for the first-fit heap allocator.
// No dependencies; used by ffha_alu and first_fit_heap_allocator.
package ffha_pkg;

    localparam int REQ_W = 11;
    localparam int OFF_W = 10;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic ST_DONE    = 1'b0;
    localparam logic ST_REFUSED = 1'b1;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

endpackage

// File: rtl/ffha_ram.sv
// Block header store: one {free, size} entry per heap offset, single port,
// registered read. Entry 0 reads as the whole free heap until first written.
module ffha_ram #(
    parameter int HEAP_BYTES   = 1024,
    parameter int HEADER_BYTES = 24,
    parameter int AW           = $clog2(HEAP_BYTES)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [AW:0]   wdata,
    output logic [AW:0]   rdata
);

    localparam logic [AW-1:0] ROOT_SIZE = AW'(HEAP_BYTES - HEADER_BYTES);

    logic [AW:0] mem [HEAP_BYTES];
    logic [AW:0] q_reg;
    logic        root_init_reg;
    logic        root_hit_reg;

    always_ff @(posedge clk)
    begin
        if (en && we)
        begin
            mem[addr] <= wdata;
        end
        if (en && !we)
        begin
            q_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_init_reg <= 1'b1;
            root_hit_reg  <= 1'b0;
        end
        else if (en)
        begin
            if (we && addr == '0)
            begin
                root_init_reg <= 1'b0;
            end
            if (!we)
            begin
                root_hit_reg <= root_init_reg && addr == '0;
            end
        end
    end

    assign rdata = root_hit_reg ? {1'b1, ROOT_SIZE} : q_reg;

endmodule

// File: rtl/ffha_alu.sv
// Shared add/subtract unit with unsigned compare for the allocator walk.
// Depends on ffha_pkg for the operation codes.
module ffha_alu #(
    parameter int LW = 13
) (
    input  ffha_pkg::alu_op_t op,
    input  logic [LW-1:0]     a,
    input  logic [LW-1:0]     b,
    output logic [LW-1:0]     res,
    output logic              ge
);

    logic          sub;
    logic [LW-1:0] b_eff;
    logic [LW:0]   sum;

    always_comb
    begin
        case (op)
            ffha_pkg::ALU_SUB: sub = 1'b1;
            default:           sub = 1'b0;
        endcase
        b_eff = sub ? ~b : b;
        sum   = {1'b0, a} + {1'b0, b_eff} + (LW+1)'(sub);
        res   = sum[LW-1:0];
        ge    = sum[LW];
    end

endmodule

// File: rtl/first_fit_heap_allocator.sv
// First-fit heap allocator with coalescing: sequencer around one shared adder.
// Depends on ffha_pkg, ffha_alu and ffha_ram.
//
// Input channel (in_valid/in_stall): one word carries mode, request_size and
// release_offset. Mode 0 allocates request_size bytes first-fit from offset 0;
// mode 1 frees the block whose payload starts at release_offset.
// Output channel (out_valid/out_stall): exactly one word per request with
// status (1 = allocate refused) and payload_offset (granted offset, else 0).
// Each request walks block headers through the single-port header store:
// read, wait, decide and next-address states per header on allocate, and
// read, wait and compare on the free search. Once the freed block is found,
// a free runs a coalescing pass over all blocks from offset 0 that merges
// adjacent free blocks. in_stall is high while a request is in progress.
// The finished word sits in an output register; a new request is taken while
// it waits. If the receiver still stalls when the next result is ready, the
// sequencer holds that result until the register drains.
// Reset empties the heap to one free block spanning it; no clearing pass.
module first_fit_heap_allocator #(
    parameter int HEAP_BYTES   = 1024,
    parameter int HEADER_BYTES = 24
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        mode,
    input  logic [ffha_pkg::REQ_W-1:0]  request_size,
    input  logic [ffha_pkg::OFF_W-1:0]  release_offset,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        status,
    output logic [ffha_pkg::OFF_W-1:0]  payload_offset
);

    localparam int AW = $clog2(HEAP_BYTES);
    localparam int LW = ((AW > 12) ? AW : 12) + 1;
    localparam logic [LW-1:0] HDR  = LW'(HEADER_BYTES);
    localparam logic [LW-1:0] HEAP = LW'(HEAP_BYTES);

    typedef enum logic [4:0] {
        S_IDLE, S_FIN,
        S_A_RD, S_A_WT, S_A_DEC, S_A_NXT, S_A_SPL, S_A_SP2, S_A_USE,
        S_F_RD, S_F_WT, S_F_CMP,
        S_C_RD, S_C_WT, S_C_NX, S_C_CHK, S_C_DEC, S_C_MRG, S_C_HP
    } state_t;

    state_t                     state_reg, state_next;
    logic [LW-1:0]              p_reg, p_next;
    logic [LW-1:0]              n_reg, n_next;
    logic [LW-1:0]              hp_reg, hp_next;
    logic [LW-1:0]              sz_reg, sz_next;
    logic [LW-1:0]              nsz_reg, nsz_next;
    logic [LW-1:0]              d_reg, d_next;
    logic                       fr_reg, fr_next;
    logic                       fit_reg, fit_next;
    logic [ffha_pkg::REQ_W-1:0] req_reg, req_next;
    logic [ffha_pkg::OFF_W-1:0] off_reg, off_next;
    logic                       st_reg, st_next;
    logic [ffha_pkg::OFF_W-1:0] po_reg, po_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       status_reg, status_next;
    logic [ffha_pkg::OFF_W-1:0] payload_reg, payload_next;

    ffha_pkg::alu_op_t alu_op;
    logic [LW-1:0]     alu_a;
    logic [LW-1:0]     alu_b;
    logic [LW-1:0]     alu_res;
    logic              alu_ge;

    logic          ram_en;
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [AW:0]   ram_wdata;
    logic [AW:0]   ram_rdata;

    logic [LW-1:0] q_sz;
    logic          q_fr;
    logic [LW-1:0] req_ext;
    logic [LW-1:0] off_ext;
    logic [LW-1:0] in_off_ext;

    ffha_alu #(
        .LW (LW)
    ) u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res),
        .ge  (alu_ge)
    );

    ffha_ram #(
        .HEAP_BYTES   (HEAP_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .AW           (AW)
    ) u_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign q_sz       = {{(LW-AW){1'b0}}, ram_rdata[AW-1:0]};
    assign q_fr       = ram_rdata[AW];
    assign req_ext    = {{(LW-ffha_pkg::REQ_W){1'b0}}, req_reg};
    assign off_ext    = {{(LW-ffha_pkg::OFF_W){1'b0}}, off_reg};
    assign in_off_ext = {{(LW-ffha_pkg::OFF_W){1'b0}}, release_offset};

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign payload_offset = payload_reg;

    always_comb
    begin
        state_next     = state_reg;
        p_next         = p_reg;
        n_next         = n_reg;
        hp_next        = hp_reg;
        sz_next        = sz_reg;
        nsz_next       = nsz_reg;
        d_next         = d_reg;
        fr_next        = fr_reg;
        fit_next       = fit_reg;
        req_next       = req_reg;
        off_next       = off_reg;
        st_next        = st_reg;
        po_next        = po_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        payload_next   = payload_reg;

        alu_op    = ffha_pkg::ALU_ADD;
        alu_a     = p_reg;
        alu_b     = HDR;
        ram_en    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = p_reg[AW-1:0];
        ram_wdata = {fr_reg, sz_reg[AW-1:0]};

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next = request_size;
                    off_next = release_offset;
                    p_next   = '0;
                    st_next  = ffha_pkg::ST_DONE;
                    po_next  = '0;
                    if (mode == ffha_pkg::MODE_ALLOC)
                    begin
                        if (request_size == '0)
                        begin
                            st_next    = ffha_pkg::ST_REFUSED;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            state_next = S_A_RD;
                        end
                    end
                    else if (in_off_ext < HDR)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_F_RD;
                    end
                end
            end

            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    status_next    = st_reg;
                    payload_next   = po_reg;
                    state_next     = S_IDLE;
                end
            end

            S_A_RD:
            begin
                if (p_reg >= HEAP)
                begin
                    st_next    = ffha_pkg::ST_REFUSED;
                    po_next    = '0;
                    state_next = S_FIN;
                end
                else
                begin
                    ram_en     = 1'b1;
                    state_next = S_A_WT;
                end
            end

            S_A_WT:
            begin
                alu_op     = ffha_pkg::ALU_SUB;
                alu_a      = q_sz;
                alu_b      = req_ext;
                sz_next    = q_sz;
                fr_next    = q_fr;
                d_next     = alu_res;
                fit_next   = q_fr && alu_ge;
                state_next = S_A_DEC;
            end

            S_A_DEC:
            begin
                if (fit_reg)
                begin
                    alu_op = ffha_pkg::ALU_SUB;
                    alu_a  = d_reg;
                    alu_b  = HDR;
                    d_next = alu_res;
                    if (alu_ge && alu_res != '0)
                    begin
                        state_next = S_A_SPL;
                    end
                    else
                    begin
                        state_next = S_A_USE;
                    end
                end
                else
                begin
                    hp_next    = alu_res;
                    state_next = S_A_NXT;
                end
            end

            S_A_NXT:
            begin
                alu_a      = hp_reg;
                alu_b      = sz_reg;
                p_next     = alu_res;
                state_next = S_A_RD;
            end

            S_A_SPL:
            begin
                hp_next    = alu_res;
                state_next = S_A_SP2;
            end

            S_A_SP2:
            begin
                alu_a      = hp_reg;
                alu_b      = req_ext;
                ram_en     = 1'b1;
                ram_we     = 1'b1;
                ram_addr   = alu_res[AW-1:0];
                ram_wdata  = {1'b1, d_reg[AW-1:0]};
                sz_next    = req_ext;
                state_next = S_A_USE;
            end

            S_A_USE:
            begin
                ram_en     = 1'b1;
                ram_we     = 1'b1;
                ram_wdata  = {1'b0, sz_reg[AW-1:0]};
                st_next    = ffha_pkg::ST_DONE;
                po_next    = alu_res[ffha_pkg::OFF_W-1:0];
                state_next = S_FIN;
            end

            S_F_RD:
            begin
                if (p_reg >= HEAP)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    ram_en     = 1'b1;
                    state_next = S_F_WT;
                end
            end

            S_F_WT:
            begin
                sz_next    = q_sz;
                fr_next    = q_fr;
                hp_next    = alu_res;
                state_next = S_F_CMP;
            end

            S_F_CMP:
            begin
                alu_a = hp_reg;
                alu_b = sz_reg;
                if (hp_reg == off_ext)
                begin
                    ram_en     = 1'b1;
                    ram_we     = 1'b1;
                    ram_wdata  = {1'b1, sz_reg[AW-1:0]};
                    p_next     = '0;
                    state_next = S_C_RD;
                end
                else if (hp_reg > off_ext)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    p_next     = alu_res;
                    state_next = S_F_RD;
                end
            end

            S_C_RD:
            begin
                ram_en     = 1'b1;
                state_next = S_C_WT;
            end

            S_C_WT:
            begin
                sz_next    = q_sz;
                fr_next    = q_fr;
                hp_next    = alu_res;
                state_next = S_C_NX;
            end

            S_C_NX:
            begin
                alu_a      = hp_reg;
                alu_b      = sz_reg;
                n_next     = alu_res;
                state_next = S_C_CHK;
            end

            S_C_CHK:
            begin
                if (n_reg >= HEAP)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    ram_en     = 1'b1;
                    ram_addr   = n_reg[AW-1:0];
                    state_next = S_C_DEC;
                end
            end

            S_C_DEC:
            begin
                nsz_next = q_sz;
                alu_a    = sz_reg;
                if (fr_reg && q_fr)
                begin
                    d_next     = alu_res;
                    state_next = S_C_MRG;
                end
                else
                begin
                    p_next     = n_reg;
                    sz_next    = q_sz;
                    fr_next    = q_fr;
                    state_next = S_C_HP;
                end
            end

            S_C_MRG:
            begin
                alu_a      = d_reg;
                alu_b      = nsz_reg;
                sz_next    = alu_res;
                ram_en     = 1'b1;
                ram_we     = 1'b1;
                ram_wdata  = {1'b1, alu_res[AW-1:0]};
                state_next = S_C_NX;
            end

            S_C_HP:
            begin
                hp_next    = alu_res;
                state_next = S_C_NX;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            p_reg         <= '0;
            n_reg         <= '0;
            hp_reg        <= '0;
            sz_reg        <= '0;
            nsz_reg       <= '0;
            d_reg         <= '0;
            fr_reg        <= 1'b0;
            fit_reg       <= 1'b0;
            req_reg       <= '0;
            off_reg       <= '0;
            st_reg        <= ffha_pkg::ST_DONE;
            po_reg        <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= ffha_pkg::ST_DONE;
            payload_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            p_reg         <= p_next;
            n_reg         <= n_next;
            hp_reg        <= hp_next;
            sz_reg        <= sz_next;
            nsz_reg       <= nsz_next;
            d_reg         <= d_next;
            fr_reg        <= fr_next;
            fit_reg       <= fit_next;
            req_reg       <= req_next;
            off_reg       <= off_next;
            st_reg        <= st_next;
            po_reg        <= po_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            payload_reg   <= payload_next;
        end
    end

endmodule
